// ===== sv/pidaw_pkg.sv =====
// ----------------------------------------------------------------------------
// pidaw_pkg: shared types, constants and saturating helpers
// Word widths, saturation bounds, register indexes and divider status.
// ----------------------------------------------------------------------------
package pidaw_pkg;

  localparam int WORD_BITS = 32;
  localparam int EFF_BITS  = (WORD_BITS > 32) ? 32 : ((WORD_BITS < 16) ? 16 : WORD_BITS);

  localparam int DATA_W   = 32;
  localparam int LIMIT_W  = 31;
  localparam int MUL_W    = 33;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int NUM_W    = 64;
  localparam int DIV_STEPS = NUM_W;
  localparam int CNT_W    = $clog2(DIV_STEPS + 1);
  localparam int IDX_W    = 3;
  localparam int FRAC_BITS = 16;

  localparam logic signed [PROD_W-1:0] SAT_HI =
    (PROD_W'(1) <<< (EFF_BITS - 1)) - PROD_W'(1);
  localparam logic signed [PROD_W-1:0] SAT_LO = -SAT_HI - PROD_W'(1);

  localparam logic [LIMIT_W-1:0]      LIMIT_RESET   = LIMIT_W'(65536000);
  localparam logic signed [DATA_W-1:0] CEILING_RESET = DATA_W'(6553600);

  localparam logic [IDX_W-1:0] REG_GAIN_P    = 3'd0;
  localparam logic [IDX_W-1:0] REG_GAIN_I    = 3'd1;
  localparam logic [IDX_W-1:0] REG_GAIN_D    = 3'd2;
  localparam logic [IDX_W-1:0] REG_LIMIT     = 3'd3;
  localparam logic [IDX_W-1:0] REG_FLOOR     = 3'd4;
  localparam logic [IDX_W-1:0] REG_CEILING   = 3'd5;
  localparam logic [IDX_W-1:0] REG_ENABLE    = 3'd6;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // Saturate a wide signed value to the working word.
  function automatic logic signed [DATA_W-1:0] sat_word(input logic signed [PROD_W-1:0] x);
    logic signed [DATA_W-1:0] r;
    if (x > SAT_HI) begin
      r = SAT_HI[DATA_W-1:0];
    end else if (x < SAT_LO) begin
      r = SAT_LO[DATA_W-1:0];
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

  // Q16.16 product back to Q16.16: floor shift, then saturate.
  function automatic logic signed [DATA_W-1:0] shr_sat(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    s = p >>> FRAC_BITS;
    return sat_word(s);
  endfunction

endpackage

// ===== sv/pidaw_if.sv =====
// ----------------------------------------------------------------------------
// pidaw_if: sample and result channels
// Valid/ready channels carrying one sample or one drive value per transaction.
// ----------------------------------------------------------------------------
interface pidaw_sample_if
  import pidaw_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] setpoint;
  logic signed [DATA_W-1:0] measured;
  logic        [DATA_W-1:0] step_time;

  modport source (output valid, output setpoint, output measured, output step_time,
                  input ready);
  modport sink   (input valid, input setpoint, input measured, input step_time,
                  output ready);
endinterface

interface pidaw_result_if
  import pidaw_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] drive;

  modport source (output valid, output drive, input ready);
  modport sink   (input valid, input drive, output ready);
endinterface

// ===== sv/pid_controller_antiwindup_unit.sv =====
// ----------------------------------------------------------------------------
// pid_controller_antiwindup_unit: PID controller with clamped integral
// Q16.16 PID step with integral clamp and anti-windup back-off, built on one
// shared multiplier and a bit-serial divider under a small sequencer.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                              | handshake
//  ---------+-----+--------------------------------------+-------------------
//  sample   | in  | setpoint, measured, step_time        | valid / ready
//  result   | out | drive                                | valid / ready
//  cfg      | in  | cfg_index, cfg_data                  | cfg_we (no stall)
//
//  An enabled sample with a nonzero step runs every sequencer state, waiting
//  in ST_DIVW on the 64-step serial divider for the D term.
//  A disabled sample or a zero step goes straight from ST_IDLE to ST_FIN
//  and leaves state alone.
//  Sample ready is high only while the sequencer is idle; a finished drive
//  waits in the output register, and a new sample is accepted meanwhile.
//  Synchronous reset loads the register defaults and clears both state words.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup_unit
  import pidaw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  pidaw_sample_if.sink      sample,
  pidaw_result_if.source    result,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [DATA_W-1:0] cfg_data
);

  // sequencer codes
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_P     = 4'd1;   // issue gain_p * error
  localparam logic [3:0] ST_INC   = 4'd2;   // take P, issue error * step
  localparam logic [3:0] ST_INT   = 4'd3;   // take increment, issue gain_d * diff
  localparam logic [3:0] ST_ACC   = 4'd4;   // start divider, update integral
  localparam logic [3:0] ST_MI    = 4'd5;   // issue gain_i * integral
  localparam logic [3:0] ST_IV    = 4'd6;   // take I
  localparam logic [3:0] ST_DIVW  = 4'd7;   // wait for D quotient
  localparam logic [3:0] ST_SUM   = 4'd8;
  localparam logic [3:0] ST_CLAMP = 4'd9;
  localparam logic [3:0] ST_UNDO  = 4'd10;  // anti-windup back-off
  localparam logic [3:0] ST_FIN   = 4'd11;  // hand result to output register

  // configuration registers
  logic signed [DATA_W-1:0] gain_p;
  logic signed [DATA_W-1:0] gain_i;
  logic signed [DATA_W-1:0] gain_d;
  logic [LIMIT_W-1:0]       integral_limit;
  logic signed [DATA_W-1:0] output_floor;
  logic signed [DATA_W-1:0] output_ceiling;
  logic                     enable;
  logic                     cfg_hit;

  // controller state
  logic signed [DATA_W-1:0] integral_sum;
  logic signed [DATA_W-1:0] previous_error;

  // per-sample working registers
  logic [3:0]               state;
  logic signed [DATA_W-1:0] err;
  logic [DATA_W-1:0]        dt;
  logic signed [DATA_W-1:0] p_term;
  logic signed [DATA_W-1:0] inc;
  logic signed [DATA_W-1:0] iv;
  logic signed [DATA_W-1:0] d_term;
  logic signed [DATA_W-1:0] sum_raw;
  logic signed [DATA_W-1:0] sum_clamped;
  logic signed [DATA_W-1:0] result_value;

  // output register
  logic                     out_valid;
  logic signed [DATA_W-1:0] drive_reg;

  // shared units
  logic signed [MUL_W-1:0]  op_a;
  logic signed [MUL_W-1:0]  op_b;
  logic signed [PROD_W-1:0] prod;
  div_status_t              div_status;
  logic signed [DATA_W-1:0] quot;
  logic                     div_start;

  // combinational helpers
  logic                     take;
  logic                     out_load;
  logic signed [DATA_W-1:0] err_in;
  logic signed [DATA_W-1:0] diff;
  logic signed [DATA_W-1:0] integ_add;
  logic signed [DATA_W-1:0] integ_clamped;
  logic signed [DATA_W-1:0] lim_pos;
  logic signed [DATA_W-1:0] lim_neg;
  logic signed [DATA_W-1:0] sum_limited;
  logic                     windup;

  assign sample.ready = (state == ST_IDLE);
  assign take         = sample.valid && sample.ready;
  assign out_load     = (state == ST_FIN) && (!out_valid || result.ready);
  assign div_start    = (state == ST_ACC);

  assign result.valid = out_valid;
  assign result.drive = drive_reg;

  // error is formed as the sample lands
  assign err_in = sat_word(PROD_W'(sample.setpoint) - PROD_W'(sample.measured));
  // derivative difference uses the error of the previous step
  assign diff   = sat_word(PROD_W'(err) - PROD_W'(previous_error));

  // integral accumulate and clamp to +/- limit
  always_comb begin
    lim_pos   = $signed({1'b0, integral_limit});
    lim_neg   = -lim_pos;
    integ_add = sat_word(PROD_W'(integral_sum) + PROD_W'(inc));
    if (integ_add > lim_pos) begin
      integ_clamped = lim_pos;
    end else if (integ_add < lim_neg) begin
      integ_clamped = lim_neg;
    end else begin
      integ_clamped = integ_add;
    end
  end

  // output limits: floor is tested first; if the limits cross, only a sum below the floor gets the floor
  always_comb begin
    if (sum_raw < output_floor) begin
      sum_limited = output_floor;
    end else if (sum_raw > output_ceiling) begin
      sum_limited = output_ceiling;
    end else begin
      sum_limited = sum_raw;
    end
  end

  assign windup = ((sum_clamped >= output_ceiling) && (iv > 0)) ||
                  ((sum_clamped <= output_floor) && (iv < 0));

  // select multiplier operands for the current step
  always_comb begin
    case (state)
      ST_P: begin
        op_a = MUL_W'(gain_p);
        op_b = MUL_W'(err);
      end
      ST_INC: begin
        op_a = MUL_W'(err);
        op_b = $signed({1'b0, dt});
      end
      ST_INT: begin
        op_a = MUL_W'(gain_d);
        op_b = MUL_W'(diff);
      end
      ST_MI: begin
        op_a = MUL_W'(gain_i);
        op_b = MUL_W'(integral_sum);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  pidaw_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  pidaw_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (prod[NUM_W-1:0]),
    .den    (dt),
    .status (div_status),
    .quot   (quot)
  );

  // configuration port; any recognized write clears the controller state
  always_comb begin
    case (cfg_index)
      REG_GAIN_P, REG_GAIN_I, REG_GAIN_D, REG_LIMIT,
      REG_FLOOR, REG_CEILING, REG_ENABLE: cfg_hit = cfg_we;
      default:                            cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p         <= '0;
      gain_i         <= '0;
      gain_d         <= '0;
      integral_limit <= LIMIT_RESET;
      output_floor   <= '0;
      output_ceiling <= CEILING_RESET;
      enable         <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_P:  gain_p         <= $signed(cfg_data);
        REG_GAIN_I:  gain_i         <= $signed(cfg_data);
        REG_GAIN_D:  gain_d         <= $signed(cfg_data);
        REG_LIMIT:   integral_limit <= cfg_data[LIMIT_W-1:0];
        REG_FLOOR:   output_floor   <= $signed(cfg_data);
        REG_CEILING: output_ceiling <= $signed(cfg_data);
        REG_ENABLE:  enable         <= cfg_data[0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  // state words: clear on reset or configuration, advance during a step
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      integral_sum   <= '0;
      previous_error <= '0;
    end else begin
      if (state == ST_ACC) begin
        integral_sum   <= integ_clamped;
        previous_error <= err;
      end else if ((state == ST_UNDO) && windup) begin
        integral_sum <= sat_word(PROD_W'(integral_sum) - PROD_W'(inc));
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (take) begin
            if (!enable || (sample.step_time == '0)) begin
              state <= ST_FIN;
            end else begin
              state <= ST_P;
            end
          end
        end
        ST_P:     state <= ST_INC;
        ST_INC:   state <= ST_INT;
        ST_INT:   state <= ST_ACC;
        ST_ACC:   state <= ST_MI;
        ST_MI:    state <= ST_IV;
        ST_IV:    state <= ST_DIVW;
        ST_DIVW: begin
          if (div_status.done) begin
            state <= ST_SUM;
          end
        end
        ST_SUM:   state <= ST_CLAMP;
        ST_CLAMP: state <= ST_UNDO;
        ST_UNDO:  state <= ST_FIN;
        ST_FIN: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default:  state <= ST_IDLE;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (take) begin
      err          <= err_in;
      dt           <= sample.step_time;
      result_value <= '0;
    end
    if (state == ST_INC) begin
      p_term <= shr_sat(prod);
    end
    if (state == ST_INT) begin
      inc <= shr_sat(prod);
    end
    if (state == ST_IV) begin
      iv <= shr_sat(prod);
    end
    if ((state == ST_DIVW) && div_status.done) begin
      d_term <= quot;
    end
    if (state == ST_SUM) begin
      sum_raw <= sat_word(PROD_W'(p_term) + PROD_W'(iv) + PROD_W'(d_term));
    end
    if (state == ST_CLAMP) begin
      sum_clamped <= sum_limited;
    end
    if (state == ST_UNDO) begin
      result_value <= sum_clamped;
    end
  end

  // output register: load when free or being drained, else hold
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      drive_reg <= result_value;
    end
  end

endmodule

// ===== sv/pidaw_mul.sv =====
// ----------------------------------------------------------------------------
// pidaw_mul: shared signed multiplier
// One registered 33x33 signed product per cycle.
// ----------------------------------------------------------------------------
module pidaw_mul
  import pidaw_pkg::*;
(
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  op_a,
  input  logic signed [MUL_W-1:0]  op_b,
  output logic signed [PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

// ===== sv/pidaw_div.sv =====
// ----------------------------------------------------------------------------
// pidaw_div: serial signed-by-unsigned divider
// Restoring division, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module pidaw_div
  import pidaw_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [NUM_W-1:0]  num,
  input  logic        [DATA_W-1:0] den,
  output div_status_t              status,
  output logic signed [DATA_W-1:0] quot
);

  logic              neg;
  logic [NUM_W-1:0]  quo;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] den_reg;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;
  logic [DATA_W:0]   trial;
  logic              fits;
  logic signed [PROD_W-1:0] signed_q;

  assign trial = {rem, quo[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_reg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg     <= num[NUM_W-1];
      quo     <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      rem     <= '0;
      den_reg <= den;
    end else if (busy) begin
      // shift one dividend bit in, subtract where it fits
      if (fits) begin
        rem <= DATA_W'(trial - {1'b0, den_reg});
      end else begin
        rem <= trial[DATA_W-1:0];
      end
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

  always_comb begin
    signed_q = neg ? -PROD_W'({1'b0, quo}) : PROD_W'({1'b0, quo});
    quot     = sat_word(signed_q);
  end

  assign status = '{busy: busy, done: done};

endmodule

// ===== sv/pidaw_checker.sv =====
// ----------------------------------------------------------------------------
// pidaw_checker: port-level checks for the PID unit
// Watches the sample and result handshakes over time.
// ----------------------------------------------------------------------------
module pidaw_checker
  import pidaw_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] drive
);

  // result holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_drive_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(drive))
    else $error("drive changed while stalled");

  // one sample at a time: ready drops after each accepted transaction
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("sample accepted while a step is running");

  // reset leaves the unit idle with an empty output register
  a_reset_idle: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("unit not idle after reset");

endmodule

bind pid_controller_antiwindup_unit pidaw_checker u_pidaw_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (sample.valid),
  .in_ready  (sample.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .drive     (result.drive)
);

// ===== sim/pid_controller_antiwindup_unit_tb.sv =====
// ----------------------------------------------------------------------------
// pid_controller_antiwindup_unit_tb: self-checking bench for the PID unit
// A table of directed samples and register writes is run first. Random
// configurations and sample streams follow under four idling patterns. Every
// drive value is compared, in the order the samples were accepted, against a
// bit-accurate Q16.16 PID predictor in the bench or a value typed in by hand.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup_unit_tb
  import pidaw_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Register index the block does not decode; a write there must change nothing.
  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef enum logic [1:0] {ROW_WRITE, ROW_SAMPLE, ROW_CHECKED} row_kind_t;

  // One line of the directed plan: a register write, a sample checked by the
  // predictor, or a sample whose drive value is typed in by hand.
  typedef struct {
    row_kind_t                kind;
    logic [IDX_W-1:0]         index;
    logic [DATA_W-1:0]        value;
    logic signed [DATA_W-1:0] setpoint;
    logic signed [DATA_W-1:0] measured;
    logic        [DATA_W-1:0] step_time;
    logic signed [DATA_W-1:0] drive;
  } row_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_we;
  logic [IDX_W-1:0]  cfg_index;
  logic [DATA_W-1:0] cfg_data;

  pidaw_sample_if smp ();
  pidaw_result_if res ();

  pid_controller_antiwindup_unit dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (smp),
    .result    (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 8 ns clock period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor copy of the register file and the two state words.
  logic signed [DATA_W-1:0]  kp, ki, kd, out_floor, out_ceil;
  logic        [LIMIT_W-1:0] int_limit;
  bit                        run_en;
  longint                    integ_acc, last_err;

  // Drive values still owed by the block, oldest first.
  logic signed [DATA_W-1:0] expected_drive_q[$];
  logic signed [DATA_W-1:0] want_drive;

  row_t        plan[$];
  int          fail_count     = 0;
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int          hold_request   = 0;
  bit          hold_done      = 1'b0;
  int          hold_left      = 0;

  // Saturate to the signed 32-bit working word.
  function automatic longint clip32(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // One PID step on the bench's own state; returns the expected drive value.
  function automatic logic signed [DATA_W-1:0] predict_drive(
      input logic signed [DATA_W-1:0] sp, input logic signed [DATA_W-1:0] ms,
      input logic [DATA_W-1:0] dt);
    longint dtl, lim, err, inc, pterm, iterm, diff, dterm, total;
    if (!run_en || dt == '0) return '0;
    dtl = longint'({32'b0, dt});
    lim = longint'({33'b0, int_limit});
    err = clip32(longint'(sp) - longint'(ms));
    pterm = clip32((longint'(kp) * err) >>> FRAC_BITS);
    inc = clip32((err * dtl) >>> FRAC_BITS);
    integ_acc = clip32(integ_acc + inc);
    if (integ_acc > lim) integ_acc = lim;
    else if (integ_acc < -lim) integ_acc = -lim;
    iterm = clip32((longint'(ki) * integ_acc) >>> FRAC_BITS);
    // Division truncates toward zero, as the block's serial divider does.
    diff = clip32(err - last_err);
    dterm = clip32((longint'(kd) * diff) / dtl);
    last_err = err;
    total = clip32(pterm + iterm + dterm);
    // Floor is tested first, so when it lies above the ceiling it wins only for totals below it.
    if (total < longint'(out_floor)) total = longint'(out_floor);
    else if (total > longint'(out_ceil)) total = longint'(out_ceil);
    // Anti-windup: back out this step's increment when pinned at a limit.
    if ((total >= longint'(out_ceil) && iterm > 0) ||
        (total <= longint'(out_floor) && iterm < 0))
      integ_acc = clip32(integ_acc - inc);
    return total[DATA_W-1:0];
  endfunction

  // Mirror a register write; any decoded write also clears the state words.
  function automatic void apply_write(input logic [IDX_W-1:0] idx,
                                      input logic [DATA_W-1:0] data);
    case (idx)
      REG_GAIN_P:  kp = data;
      REG_GAIN_I:  ki = data;
      REG_GAIN_D:  kd = data;
      REG_LIMIT:   int_limit = data[LIMIT_W-1:0];
      REG_FLOOR:   out_floor = data;
      REG_CEILING: out_ceil = data;
      REG_ENABLE:  run_en = data[0];
      default:     return;
    endcase
    integ_acc = 0;
    last_err = 0;
  endfunction

  function automatic void add_write(input logic [IDX_W-1:0] idx,
                                    input logic [DATA_W-1:0] data);
    plan.push_back('{ROW_WRITE, idx, data, '0, '0, '0, '0});
  endfunction

  function automatic void add_sample(input logic signed [DATA_W-1:0] sp,
                                     input logic signed [DATA_W-1:0] ms,
                                     input logic [DATA_W-1:0] dt);
    plan.push_back('{ROW_SAMPLE, REG_GAIN_P, '0, sp, ms, dt, '0});
  endfunction

  function automatic void add_checked(input logic signed [DATA_W-1:0] sp,
                                      input logic signed [DATA_W-1:0] ms,
                                      input logic [DATA_W-1:0] dt,
                                      input logic signed [DATA_W-1:0] drive);
    plan.push_back('{ROW_CHECKED, REG_GAIN_P, '0, sp, ms, dt, drive});
  endfunction

  // Mostly levels within +/-256.0, now and then any 32-bit value.
  function automatic logic [DATA_W-1:0] pick_level();
    if ($urandom_range(4) == 0) return $urandom;
    return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
  endfunction

  // Mostly steps up to 2.0 s, with zero, tiny and full-range steps mixed in.
  function automatic logic [DATA_W-1:0] pick_step();
    case ($urandom_range(9))
      0:       return '0;
      1:       return $urandom;
      2:       return $urandom_range(1, 16);
      default: return $urandom_range(1, 32'h0002_0000);
    endcase
  endfunction

  // Drop valid and wait until every owed drive value has come back.
  task automatic settle();
    smp.valid <= 1'b0;
    while (expected_drive_q.size() != 0) @(posedge clk);
  endtask

  // Write one register; the caller keeps the block idle around the write.
  // The write enable is lowered by the next sample offered.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    apply_write(idx, data);
  endtask

  // Offer one sample, hold it until the transaction completes, then record
  // the drive value owed for it.
  task automatic offer(input logic signed [DATA_W-1:0] sp,
                       input logic signed [DATA_W-1:0] ms,
                       input logic [DATA_W-1:0] dt, input bit typed,
                       input logic signed [DATA_W-1:0] typed_drive);
    logic signed [DATA_W-1:0] model_drive;
    cfg_we <= 1'b0;
    while ($urandom_range(99) < src_idle_pct) begin
      smp.valid <= 1'b0;
      @(posedge clk);
    end
    smp.valid     <= 1'b1;
    smp.setpoint  <= sp;
    smp.measured  <= ms;
    smp.step_time <= dt;
    @(posedge clk);
    while (!smp.ready) @(posedge clk);
    model_drive = predict_drive(sp, ms, dt);
    expected_drive_q.push_back(typed ? typed_drive : model_drive);
  endtask

  // Rewrite all registers or a random subset, sometimes poking the unused index.
  task automatic shuffle_config(input bit every_reg);
    logic [DATA_W-1:0] lo, hi, t;
    logic [IDX_W-1:0]  ri;
    bit                any;
    any = 1'b0;
    lo = -$urandom_range(0, 32'h00C8_0000);
    hi = $urandom_range(0, 32'h00C8_0000);
    case ($urandom_range(7))
      0: begin
        t = lo; lo = hi; hi = t;
      end
      1: begin
        lo = $urandom; hi = $urandom;
      end
      default: ;
    endcase
    for (int r = 0; r <= int'(REG_ENABLE); r++) begin
      ri = IDX_W'(r);
      if (every_reg || $urandom_range(1) == 1) begin
        case (ri)
          REG_LIMIT: begin
            case ($urandom_range(7))
              0:       t = '0;
              1:       t = $urandom;
              default: t = $urandom_range(0, 32'h01F4_0000);
            endcase
          end
          REG_FLOOR:   t = lo;
          REG_CEILING: t = hi;
          REG_ENABLE: begin
            t = $urandom;
            t[0] = ($urandom_range(9) != 0);
          end
          default: begin
            // Gains: mostly within +/-4.0, sometimes extreme or arbitrary.
            case ($urandom_range(9))
              0:       t = 32'h7FFF_FFFF;
              1:       t = 32'h8000_0000;
              2, 3:    t = $urandom;
              default: t = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            endcase
          end
        endcase
        write_reg(ri, t);
        any = 1'b1;
      end
    end
    if ($urandom_range(7) == 0) write_reg(REG_UNUSED, $urandom);
    if (!any) write_reg(REG_ENABLE, 32'd1);
  endtask

  // Result side: check every completed transaction against the oldest owed
  // value, and drive ready with random stalls or a long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (expected_drive_q.size() == 0) begin
          $error("drive: unexpected transaction, actual %0d", res.drive);
          fail_count++;
        end else begin
          want_drive = expected_drive_q.pop_front();
          if (res.drive !== want_drive) begin
            $error("drive mismatch: expected %0d, actual %0d", want_drive, res.drive);
            fail_count++;
          end
        end
      end
      // Count the hold-off here so it runs independently of the sender.
      if (hold_request > 0 && !hold_done) begin
        hold_left = hold_request;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Main sequence: reset, directed plan, then random phases.
  initial begin
    int unsigned              src_tab[4];
    int unsigned              sink_tab[4];
    logic signed [DATA_W-1:0] seg_level, sp, ms;
    logic        [DATA_W-1:0] dt;

    // Drive every input to a known value from time zero.
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_GAIN_P;
    cfg_data      <= '0;
    smp.valid     <= 1'b0;
    smp.setpoint  <= '0;
    smp.measured  <= '0;
    smp.step_time <= '0;

    // Predictor starts at the register defaults with cleared state.
    kp = '0; ki = '0; kd = '0;
    int_limit = LIMIT_RESET;
    out_floor = '0;
    out_ceil  = CEILING_RESET;
    run_en    = 1'b0;
    integ_acc = 0;
    last_err  = 0;

    // Idling per phase: none, sender only, receiver only, both.
    src_tab  = '{0, 55, 0, 34};
    sink_tab = '{0, 0, 55, 34};

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed plan. Q16.16: 1.0 = 0x0001_0000, 100.0 = 0x0064_0000.
    // Disabled out of reset: zero drive.
    add_checked(32'h0064_0000, 32'h0, 32'h0001_0000, 32'h0);
    add_write(REG_ENABLE, 32'd1);
    // All gains still zero; then a zero step forces zero too.
    add_checked(32'h0064_0000, 32'h0, 32'h0001_0000, 32'h0);
    add_checked(32'h0005_0000, 32'h0, 32'h0, 32'h0);
    // Unity P gain: 50.0 error gives 50.0; extreme errors pin to the limits.
    add_write(REG_GAIN_P, 32'h0001_0000);
    add_checked(32'h0032_0000, 32'h0, 32'h0001_0000, 32'h0032_0000);
    add_checked(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h0064_0000);
    add_checked(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 32'h0);
    // Unity I gain: drive into the ceiling so the increment is backed out.
    add_write(REG_GAIN_I, 32'h0001_0000);
    add_sample(32'h00C8_0000, 32'h0, 32'h0001_0000);
    add_sample(32'h00C8_0000, 32'h0, 32'h0001_0000);
    add_sample(32'hFF38_0000, 32'h0, 32'h0001_0000);
    // Integral limit at zero, then at its maximum (bit 31 of the data dropped).
    add_write(REG_LIMIT, 32'h0);
    add_sample(32'hFFE2_0000, 32'h0, 32'h0001_0000);
    add_write(REG_LIMIT, 32'hFFFF_FFFF);
    add_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    add_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    // Extreme D gains over the shortest step saturate the D term.
    add_write(REG_GAIN_D, 32'h7FFF_FFFF);
    add_sample(32'h0001_0000, 32'h0, 32'h1);
    add_write(REG_GAIN_D, 32'h8000_0000);
    add_sample(32'hFFFF_0000, 32'h0, 32'h1);
    add_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h1);
    // Extreme gains with the output limits opened all the way.
    add_write(REG_GAIN_P, 32'h8000_0000);
    add_write(REG_GAIN_I, 32'h7FFF_FFFF);
    add_write(REG_FLOOR, 32'h8000_0000);
    add_write(REG_CEILING, 32'h7FFF_FFFF);
    add_sample(32'h0032_0000, 32'h0, 32'h0001_0000);
    add_sample(32'hFFCE_0000, 32'h0, 32'hFFFF_FFFF);
    // Floor 10.0 above ceiling -10.0: a zero sum lands on the floor.
    add_write(REG_GAIN_P, 32'h0);
    add_write(REG_GAIN_I, 32'h0);
    add_write(REG_GAIN_D, 32'h0);
    add_write(REG_FLOOR, 32'h000A_0000);
    add_write(REG_CEILING, 32'hFFF6_0000);
    add_checked(32'h0, 32'h0, 32'h0001_0000, 32'h000A_0000);
    add_write(REG_GAIN_P, 32'h0001_0000);
    add_sample(32'h0032_0000, 32'h0, 32'h0001_0000);
    // Undecoded index: state must survive into the next step.
    add_write(REG_UNUSED, 32'h1234_5678);
    add_sample(32'h0032_0000, 32'h0, 32'h0001_0000);
    // Enable data with bit 0 low disables the block.
    add_write(REG_ENABLE, 32'hFFFF_FFFE);
    add_checked(32'h0032_0000, 32'h0, 32'h0001_0000, 32'h0);
    // Ordinary tuning: -2.0, 0.5, 0.25, limits +/-50.0, integral bound 100.0.
    add_write(REG_ENABLE, 32'd1);
    add_write(REG_FLOOR, 32'hFFCE_0000);
    add_write(REG_CEILING, 32'h0032_0000);
    add_write(REG_GAIN_P, 32'hFFFE_0000);
    add_write(REG_GAIN_I, 32'h0000_8000);
    add_write(REG_GAIN_D, 32'h0000_4000);
    add_write(REG_LIMIT, 32'h0064_0000);
    add_sample(32'hFFEC_0000, 32'h0003_8000, 32'h0000_8000);
    add_sample(32'h0014_0000, 32'h0, 32'h0000_0100);
    add_sample(32'h0, 32'h0014_0000, 32'h0002_0000);

    // Walk the plan; hold the block idle around every register write.
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        settle();
        write_reg(plan[i].index, plan[i].value);
      end else begin
        offer(plan[i].setpoint, plan[i].measured, plan[i].step_time,
              plan[i].kind == ROW_CHECKED, plan[i].drive);
      end
    end

    // Random part: 4 phases x 7 segments x 50 samples. Each segment settles,
    // retunes, then tracks one level with small measurement offsets, mixed
    // with arbitrary samples.
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct   = src_tab[ph];
      sink_stall_pct = sink_tab[ph];
      for (int sg = 0; sg < 7; sg++) begin
        settle();
        shuffle_config(sg == 0);
        // Stall the result side long enough for the block to back up its
        // input while samples keep coming.
        if (ph == 0 && sg == 1) hold_request = 400;
        seg_level = pick_level();
        for (int k = 0; k < 50; k++) begin
          sp = ($urandom_range(9) < 7) ? seg_level : $urandom;
          if ($urandom_range(9) < 7) begin
            ms = seg_level + ($urandom_range(0, 32'h0020_0000) - 32'h0010_0000);
          end else begin
            ms = pick_level();
          end
          dt = pick_step();
          offer(sp, ms, dt, 1'b0, '0);
        end
      end
    end

    // Drain, then give the block time to emit anything stray.
    settle();
    repeat (100) @(posedge clk);
    if (expected_drive_q.size() != 0) begin
      $error("drive: %0d transactions never arrived", expected_drive_q.size());
    end
    if (fail_count == 0 && expected_drive_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #10ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
